[rtl/lcw_pkg.sv]
`default_nettype none

package lcw_pkg;

    localparam int LCW_MAX_BANDS = 32;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOCKED_MODE  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TICK_RATE     = 2'd3;

    localparam logic signed [16:0] LEVEL_MAX = 17'sd32768;
    localparam logic signed [16:0] LEVEL_MIN = -17'sd32768;
    localparam logic [15:0] VEL_MAX   = 16'd32768;
    localparam logic [15:0] WIDTH_MAX = 16'd32768;

    localparam logic [5:0]  RST_CHANNEL_COUNT = 6'd8;
    localparam logic [15:0] RST_WINDOW_WIDTH  = 16'd16384;
    localparam logic [15:0] RST_TICK_RATE     = 16'd1000;

    typedef struct packed {
        logic [5:0]  channel_count;
        logic [15:0] window_width;
        logic        clocked_mode;
        logic [15:0] tick_rate;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/lcw_band.sv]
`default_nettype none

module lcw_band
    import lcw_pkg::*;
#(
    parameter int MAX_BANDS = LCW_MAX_BANDS
)
(
    input  wire logic signed [16:0] lvl,
    input  wire cfg_t               cfg,
    output logic [31:0]             bitmap
);

    logic [5:0]            n;
    logic [15:0]           ww;
    logic [16:0]           lim;
    logic signed [23:0]    scaled;
    logic [MAX_BANDS-1:0]  hits;

    always_comb
    begin
        if (cfg.channel_count == 6'd0)
            n = 6'd1;
        else if (cfg.channel_count > 6'(MAX_BANDS))
            n = 6'(MAX_BANDS);
        else
            n = cfg.channel_count;
        ww = (cfg.window_width > WIDTH_MAX) ? WIDTH_MAX : cfg.window_width;
    end

    assign lim    = {ww, 1'b0};
    assign scaled = $signed({18'b0, n}) * $signed({{7{lvl[16]}}, lvl});

    // band centre sits at (2c+1-n)*one after scaling by n
    for (genvar c = 0; c < MAX_BANDS; c++)
    begin : g_band
        localparam logic [5:0] IDX = 6'(c);
        localparam logic [5:0] ODD = 6'(2 * c + 1);
        logic signed [7:0]  k;
        logic signed [24:0] ctr;
        logic signed [24:0] d;
        logic [24:0]        mag;

        assign k   = $signed({2'b00, ODD}) - $signed({2'b00, n});
        assign ctr = {{2{k[7]}}, k, 15'b0};
        assign d   = {scaled[23], scaled} - ctr;
        assign mag = d[24] ? 25'(-d) : 25'(d);
        assign hits[c] = (IDX < n) && (mag <= {8'b0, lim});
    end

    always_comb
    begin
        bitmap = '0;
        bitmap[MAX_BANDS-1:0] = hits;
    end

endmodule

`default_nettype wire

[rtl/lcw_vel.sv]
`default_nettype none

module lcw_vel
    import lcw_pkg::*;
(
    input  wire logic signed [16:0] lvl,
    input  wire logic signed [16:0] prev,
    input  wire logic               first,
    input  wire logic [15:0]        rate,
    output logic [15:0]             vel
);

    logic signed [17:0] d;
    logic [17:0]        ad;
    logic [32:0]        prod;
    logic [31:0]        half;

    assign d    = {lvl[16], lvl} - {prev[16], prev};
    assign ad   = d[17] ? 18'(-d) : 18'(d);
    assign prod = {16'b0, ad[16:0]} * {17'b0, rate};
    assign half = prod[32:1];

    always_comb
    begin
        if (first || (rate == 16'd0))
            vel = 16'd0;
        else if (half > {16'b0, VEL_MAX})
            vel = VEL_MAX;
        else
            vel = half[15:0];
    end

endmodule

`default_nettype wire

[rtl/level_to_channel_window_decoder.sv]
// Throughput: one request per cycle unless out_stall holds a valid result;
// the input register feeds band compare and velocity multiply, which land
// in the output register.
// Reset (rst_n low, async): pipeline empty, registers at defaults, first
// tick flag set, pending pulse and latched bitmap cleared.
`default_nettype none

module level_to_channel_window_decoder
    import lcw_pkg::*;
#(
    parameter int MAX_BANDS = LCW_MAX_BANDS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic signed [16:0]     level,
    input  wire logic                   clock_pulse,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [15:0]                 velocity,
    output logic signed [16:0]          level_out,
    output logic                        gate,
    output logic [31:0]                 band_bitmap,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]            cfg_data
);

    cfg_t cfg_reg;

    logic               s1_valid_reg;
    logic signed [16:0] s1_level_reg;
    logic               s1_pulse_reg;

    logic signed [16:0] prev_reg;
    logic               first_reg;
    logic               pend_reg;
    logic [31:0]        latched_reg;

    logic               out_valid_reg;
    logic [15:0]        vel_reg;
    logic signed [16:0] lvl_out_reg;
    logic [31:0]        map_out_reg;

    logic               adv;
    logic               take;
    logic signed [16:0] lvl;
    logic [31:0]        map;
    logic [15:0]        vel;
    logic               pend_eff;
    logic               pend_next;
    logic [31:0]        latched_next;
    logic [31:0]        map_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count <= RST_CHANNEL_COUNT;
            cfg_reg.window_width  <= RST_WINDOW_WIDTH;
            cfg_reg.clocked_mode  <= 1'b0;
            cfg_reg.tick_rate     <= RST_TICK_RATE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_data[5:0];
                REG_WINDOW_WIDTH:  cfg_reg.window_width  <= cfg_data;
                REG_CLOCKED_MODE:  cfg_reg.clocked_mode  <= cfg_data[0];
                REG_TICK_RATE:     cfg_reg.tick_rate     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !adv;
    assign take     = s1_valid_reg && adv;

    always_comb
    begin
        if (s1_level_reg > LEVEL_MAX)
            lvl = LEVEL_MAX;
        else if (s1_level_reg < LEVEL_MIN)
            lvl = LEVEL_MIN;
        else
            lvl = s1_level_reg;
    end

    lcw_band #(
        .MAX_BANDS (MAX_BANDS)
    ) u_band (
        .lvl    (lvl),
        .cfg    (cfg_reg),
        .bitmap (map)
    );

    lcw_vel u_vel (
        .lvl   (lvl),
        .prev  (prev_reg),
        .first (first_reg),
        .rate  (cfg_reg.tick_rate),
        .vel   (vel)
    );

    // a pulse seen in free-running mode waits for the next clocked tick
    always_comb
    begin
        pend_eff     = pend_reg || s1_pulse_reg;
        pend_next    = pend_eff;
        latched_next = latched_reg;
        map_next     = map;
        if (cfg_reg.clocked_mode)
        begin
            if (pend_eff)
            begin
                latched_next = map;
                pend_next    = 1'b0;
            end
            map_next = latched_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            first_reg     <= 1'b1;
            pend_reg      <= 1'b0;
            latched_reg   <= '0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (adv)
                out_valid_reg <= s1_valid_reg;
            if (take)
            begin
                prev_reg    <= lvl;
                first_reg   <= 1'b0;
                pend_reg    <= pend_next;
                latched_reg <= latched_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_level_reg <= level;
            s1_pulse_reg <= clock_pulse;
        end
        if (take)
        begin
            vel_reg     <= vel;
            lvl_out_reg <= lvl;
            map_out_reg <= map_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign velocity    = vel_reg;
    assign level_out   = lvl_out_reg;
    assign band_bitmap = map_out_reg;
    assign gate        = (map_out_reg != 32'd0);

endmodule

`default_nettype wire

[rtl/lcw_checker.sv]
`default_nettype none

module lcw_checker
    import lcw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_stall,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic [15:0]            velocity,
    input  wire logic signed [16:0]     level_out,
    input  wire logic                   gate,
    input  wire logic [31:0]            band_bitmap
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_gate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gate == (band_bitmap != 32'd0)))
        else $error("gate disagrees with bitmap");

    a_vel_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (velocity <= VEL_MAX))
        else $error("velocity above saturation");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed({level_out[16], level_out}) <= 18'sd32768))
        else $error("level not clamped");

    a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

endmodule

bind level_to_channel_window_decoder lcw_checker u_lcw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .velocity    (velocity),
    .level_out   (level_out),
    .gate        (gate),
    .band_bitmap (band_bitmap)
);

`default_nettype wire
